>>> sv/wpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_pkg
// shared types, codes and helpers of the word pattern matcher
// ----------------------------------------------------------------------------
package wpm_pkg;

    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd3;

    // match modes
    localparam logic [1:0] MODE_SUBSTR = 2'd0;
    localparam logic [1:0] MODE_EXACT  = 2'd1;
    localparam logic [1:0] MODE_NOCASE = 2'd2;

    // record kinds
    localparam logic KIND_WORD = 1'b0;
    localparam logic KIND_LINE = 1'b1;

    localparam logic [7:0] CH_NEWLINE = 8'd10;

    localparam int EV_DEPTH  = 4;
    localparam int OUT_DEPTH = 4;

    localparam logic [31:0] MAX32 = '1;
    localparam logic [9:0]  MAX10 = '1;

    typedef struct packed {
        logic       hit;
        logic       line_close;
        logic       eot;
        logic [8:0] word_index;
    } t_event;

    typedef struct packed {
        logic        record_kind;
        logic [31:0] line_number;
        logic [8:0]  word_index;
        logic [9:0]  line_hit_count;
        logic [9:0]  line_length;
        logic [31:0] total_hits;
        logic [31:0] total_hit_lines;
        logic [9:0]  longest_length;
        logic [31:0] longest_line_number;
        logic        last_of_step;
    } t_record;

    // space . , ? ! ; : ( ) double quote newline, and the zero byte
    function automatic logic is_delim(input logic [7:0] c);
        return c == 8'd0  || c == 8'd32 || c == 8'd46 || c == 8'd44 ||
               c == 8'd63 || c == 8'd33 || c == 8'd59 || c == 8'd58 ||
               c == 8'd40 || c == 8'd41 || c == 8'd34 || c == CH_NEWLINE;
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
    endfunction

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        return (v == MAX32) ? v : v + 32'd1;
    endfunction

    function automatic logic [9:0] sat_inc10(input logic [9:0] v);
        return (v == MAX10) ? v : v + 10'd1;
    endfunction

endpackage

>>> sv/wpm_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_fifo
// small first-in first-out queue with registered storage
// ----------------------------------------------------------------------------
module wpm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> sv/wpm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_front
// tokenizer and pattern compare: turns bytes into word hit and line events
// ----------------------------------------------------------------------------
module wpm_front #(
    parameter int LINE_BUFFER_BYTES = 1024,
    parameter int PATTERN_BYTES     = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [wpm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [63:0]                      i_cfg_data,
    input  logic                             i_take,
    input  logic [7:0]                       i_char_code,
    input  logic                             i_end_of_text,
    output logic                             o_ev_push,
    output wpm_pkg::t_event                  o_ev,
    output logic [$clog2(LINE_BUFFER_BYTES)-1:0] o_ev_len
);

    import wpm_pkg::*;

    localparam int LW  = $clog2(LINE_BUFFER_BYTES);
    localparam int PLW = $clog2(PATTERN_BYTES + 1);
    localparam int PIW = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
    localparam logic [LW-1:0] BREAK_LEN = LW'(LINE_BUFFER_BYTES - 1);

    // configuration
    logic [7:0]     r_pat [PATTERN_BYTES];
    logic [PLW-1:0] r_plen;
    logic [1:0]     r_mode;

    // word and line state
    logic [7:0]    r_win [PATTERN_BYTES];
    logic [9:0]    r_word_len;
    logic          r_word_eq;
    logic          r_word_hit;
    logic [9:0]    r_words;
    logic [LW-1:0] r_bytes;

    logic [7:0]    w_win [PATTERN_BYTES];
    logic          w_delim;
    logic [LW-1:0] w_bytes_next;
    logic          w_line_close;
    logic [7:0]    w_pat_pos;
    logic [7:0]    w_a;
    logic [7:0]    w_b;
    logic          w_eq_add;
    logic [9:0]    w_len_add;
    logic          w_sub;
    logic          w_hit_add;
    logic [9:0]    w_len_p;
    logic          w_eq_p;
    logic          w_hit_p;
    logic          w_close;
    logic          w_match;
    logic          w_word_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < PATTERN_BYTES; b++) begin
                r_pat[b] <= '0;
            end
            r_plen <= '0;
            r_mode <= MODE_SUBSTR;
        end else if (i_cfg_we) begin
            for (int b = 0; b < PATTERN_BYTES; b++) begin
                if (i_cfg_index == ((b < 8) ? REG_PAT_LOW : REG_PAT_HIGH)) begin
                    r_pat[b] <= i_cfg_data[8*(b%8) +: 8];
                end
            end
            if (i_cfg_index == REG_PAT_LEN) begin
                r_plen <= (i_cfg_data[4:0] > 5'(PATTERN_BYTES)) ?
                          PLW'(PATTERN_BYTES) : PLW'(i_cfg_data[4:0]);
            end
            if (i_cfg_index == REG_MODE) begin
                r_mode <= i_cfg_data[1:0];
            end
        end
    end

    always_comb begin
        w_delim      = is_delim(i_char_code);
        w_bytes_next = r_bytes + 1'b1;
        w_line_close = (i_char_code == CH_NEWLINE) || (w_bytes_next == BREAK_LEN) ||
                       i_end_of_text;

        // prefix compare at the current word position
        w_pat_pos = r_pat[r_word_len[PIW-1:0]];
        w_a       = (r_mode == MODE_NOCASE) ? fold_case(i_char_code) : i_char_code;
        w_b       = (r_mode == MODE_NOCASE) ? fold_case(w_pat_pos) : w_pat_pos;
        w_eq_add  = r_word_eq && (r_word_len < 10'(r_plen)) && (w_a == w_b);
        w_len_add = sat_inc10(r_word_len);

        // substring compare over the byte window, newest byte first
        w_win[0] = i_char_code;
        for (int i = 1; i < PATTERN_BYTES; i++) begin
            w_win[i] = r_win[i-1];
        end
        w_sub = 1'b1;
        for (int i = 0; i < PATTERN_BYTES; i++) begin
            if (PLW'(i) < r_plen) begin
                if (w_win[i] != r_pat[PIW'(int'(r_plen) - 1 - i)]) begin
                    w_sub = 1'b0;
                end
            end
        end
        w_hit_add = r_word_hit ||
                    ((r_plen != '0) && (w_len_add >= 10'(r_plen)) && w_sub);

        w_len_p = w_delim ? r_word_len : w_len_add;
        w_eq_p  = w_delim ? r_word_eq  : w_eq_add;
        w_hit_p = w_delim ? r_word_hit : w_hit_add;
        w_close = (w_delim || w_line_close) && (w_len_p != '0);

        case (r_mode)
            MODE_SUBSTR: w_match = w_hit_p || (r_plen == '0);
            MODE_EXACT, MODE_NOCASE: w_match = w_eq_p && (w_len_p == 10'(r_plen));
            default: w_match = 1'b0;
        endcase
        w_word_hit = w_close && w_match;
    end

    always_ff @(posedge i_clk) begin
        if (i_take && !w_delim) begin
            for (int i = 0; i < PATTERN_BYTES; i++) begin
                r_win[i] <= w_win[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_len <= '0;
            r_word_eq  <= 1'b1;
            r_word_hit <= 1'b0;
            r_words    <= '0;
            r_bytes    <= '0;
        end else if (i_take) begin
            if (i_end_of_text) begin
                r_word_len <= '0;
                r_word_eq  <= 1'b1;
                r_word_hit <= 1'b0;
                r_words    <= '0;
                r_bytes    <= '0;
            end else begin
                if (w_close) begin
                    r_word_len <= '0;
                    r_word_eq  <= 1'b1;
                    r_word_hit <= 1'b0;
                    r_words    <= sat_inc10(r_words);
                end else begin
                    r_word_len <= w_len_p;
                    r_word_eq  <= w_eq_p;
                    r_word_hit <= w_hit_p;
                end
                if (w_line_close) begin
                    r_bytes <= '0;
                    r_words <= '0;
                end else begin
                    r_bytes <= w_bytes_next;
                end
            end
        end
    end

    assign o_ev_push       = i_take && (w_word_hit || w_line_close);
    assign o_ev.hit        = w_word_hit;
    assign o_ev.line_close = w_line_close;
    assign o_ev.eot        = i_end_of_text;
    assign o_ev.word_index = r_words[8:0];
    assign o_ev_len        = w_bytes_next;

endmodule

>>> sv/wpm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_back
// hit and line bookkeeping: turns events into word and line records
// ----------------------------------------------------------------------------
module wpm_back #(
    parameter int LINE_BUFFER_BYTES = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_ev_valid,
    input  wpm_pkg::t_event                      i_ev,
    input  logic [$clog2(LINE_BUFFER_BYTES)-1:0] i_ev_len,
    output logic                                 o_ev_pop,
    input  logic                                 i_out_full,
    output logic                                 o_rec_push,
    output wpm_pkg::t_record                     o_rec
);

    import wpm_pkg::*;

    localparam int LW = $clog2(LINE_BUFFER_BYTES);

    typedef enum logic {
        PH_WORD,
        PH_LINE
    } t_phase;

    t_phase        r_phase;
    logic [9:0]    r_hits;
    logic [31:0]   r_line;
    logic [31:0]   r_total;
    logic [31:0]   r_hit_lines;
    logic [LW-1:0] r_longest;
    logic [31:0]   r_longest_at;

    logic          w_fire;
    logic          w_word;
    logic [9:0]    w_hits_inc;
    logic [31:0]   w_total_inc;
    logic [31:0]   w_hit_lines_inc;
    logic          w_longer;
    logic [LW-1:0] w_longest_new;
    logic [31:0]   w_longest_at_new;

    always_comb begin
        w_fire           = i_ev_valid && !i_out_full;
        w_word           = (r_phase == PH_WORD) && i_ev.hit;
        w_hits_inc       = sat_inc10(r_hits);
        w_total_inc      = sat_inc32(r_total);
        w_hit_lines_inc  = (r_hits == '0) ? sat_inc32(r_hit_lines) : r_hit_lines;
        w_longer         = i_ev_len > r_longest;
        w_longest_new    = w_longer ? i_ev_len : r_longest;
        w_longest_at_new = w_longer ? r_line : r_longest_at;

        o_rec_push = w_fire;
        o_ev_pop   = w_fire && !(w_word && i_ev.line_close);

        o_rec.line_number = r_line;
        o_rec.line_length = 10'(i_ev_len);
        if (w_word) begin
            o_rec.record_kind         = KIND_WORD;
            o_rec.word_index          = i_ev.word_index;
            o_rec.line_hit_count      = w_hits_inc;
            o_rec.total_hits          = w_total_inc;
            o_rec.total_hit_lines     = w_hit_lines_inc;
            o_rec.longest_length      = 10'(r_longest);
            o_rec.longest_line_number = r_longest_at;
            o_rec.last_of_step        = !i_ev.line_close;
        end else begin
            o_rec.record_kind         = KIND_LINE;
            o_rec.word_index          = '0;
            o_rec.line_hit_count      = r_hits;
            o_rec.total_hits          = r_total;
            o_rec.total_hit_lines     = r_hit_lines;
            o_rec.longest_length      = 10'(w_longest_new);
            o_rec.longest_line_number = w_longest_at_new;
            o_rec.last_of_step        = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_WORD;
            r_hits       <= '0;
            r_line       <= '0;
            r_total      <= '0;
            r_hit_lines  <= '0;
            r_longest    <= '0;
            r_longest_at <= '0;
        end else if (w_fire) begin
            if (w_word) begin
                r_hits      <= w_hits_inc;
                r_total     <= w_total_inc;
                r_hit_lines <= w_hit_lines_inc;
                r_phase     <= i_ev.line_close ? PH_LINE : PH_WORD;
            end else begin
                r_phase <= PH_WORD;
                if (i_ev.eot) begin
                    r_hits       <= '0;
                    r_line       <= '0;
                    r_total      <= '0;
                    r_hit_lines  <= '0;
                    r_longest    <= '0;
                    r_longest_at <= '0;
                end else begin
                    r_longest    <= w_longest_new;
                    r_longest_at <= w_longest_at_new;
                    r_line       <= sat_inc32(r_line);
                    r_hits       <= '0;
                end
            end
        end
    end

endmodule

>>> sv/word_pattern_matcher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_pattern_matcher_top
// byte stream word splitter and pattern matcher with per-line statistics
// ----------------------------------------------------------------------------
// One text byte is taken per clock whenever full is low; full rises only when
// the four-entry event queue between the tokenizer and the bookkeeping stage
// is full. A byte's event is registered in the event queue, and its records are
// then registered in the result queue, where they can be popped. The
// bookkeeping stage writes one record per cycle while the result queue has
// room, so a byte that both ends a matching word and closes its line holds
// that stage until both of its records are written; all other bytes yield
// one record or none there. Sustained rate is one byte per cycle while results
// are popped as fast as they come. There is no clearing pass after reset.

module word_pattern_matcher_top #(
    parameter int LINE_BUFFER_BYTES = 1024,
    parameter int PATTERN_BYTES     = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [wpm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                   i_cfg_data,
    // text byte side
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    i_char_code,
    input  logic                          i_end_of_text,
    // record side
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_record_kind,
    output logic [31:0]                   o_line_number,
    output logic [8:0]                    o_word_index,
    output logic [9:0]                    o_line_hit_count,
    output logic [9:0]                    o_line_length,
    output logic [31:0]                   o_total_hits,
    output logic [31:0]                   o_total_hit_lines,
    output logic [9:0]                    o_longest_length,
    output logic [31:0]                   o_longest_line_number,
    output logic                          o_last_of_step
);

    import wpm_pkg::*;

    localparam int LW  = $clog2(LINE_BUFFER_BYTES);
    localparam int EVW = $bits(t_event) + LW;
    localparam int RW  = $bits(t_record);

    // front side: a pushed byte is taken when the event queue has room
    logic           w_take;
    logic           w_ev_push;
    t_event         w_ev_in;
    logic [LW-1:0]  w_ev_len_in;

    // event queue
    logic           w_ev_full;
    logic           w_ev_empty;
    logic           w_ev_pop;
    logic [EVW-1:0] w_ev_q;
    t_event         w_ev_head;
    logic [LW-1:0]  w_ev_len;

    // result queue
    logic           w_rec_push;
    t_record        w_rec;
    logic           w_out_full;
    logic [RW-1:0]  w_out_q;
    t_record        w_out_head;

    assign w_take = push && !full;
    assign full   = w_ev_full;

    wpm_front #(
        .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES),
        .PATTERN_BYTES     (PATTERN_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_take        (w_take),
        .i_char_code   (i_char_code),
        .i_end_of_text (i_end_of_text),
        .o_ev_push     (w_ev_push),
        .o_ev          (w_ev_in),
        .o_ev_len      (w_ev_len_in)
    );

    // events carry the hit, line-close and end-of-text flags and the word index plus the running line length
    wpm_fifo #(
        .WIDTH (EVW),
        .DEPTH (EV_DEPTH)
    ) u_ev_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_ev_push),
        .i_data  ({w_ev_in, w_ev_len_in}),
        .o_full  (w_ev_full),
        .i_pop   (w_ev_pop),
        .o_data  (w_ev_q),
        .o_empty (w_ev_empty)
    );

    assign w_ev_head = t_event'(w_ev_q[EVW-1:LW]);
    assign w_ev_len  = w_ev_q[LW-1:0];

    wpm_back #(
        .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ev_valid (!w_ev_empty),
        .i_ev       (w_ev_head),
        .i_ev_len   (w_ev_len),
        .o_ev_pop   (w_ev_pop),
        .i_out_full (w_out_full),
        .o_rec_push (w_rec_push),
        .o_rec      (w_rec)
    );

    // finished records wait here until the consumer pops them
    wpm_fifo #(
        .WIDTH (RW),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rec_push),
        .i_data  (w_rec),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (w_out_q),
        .o_empty (empty)
    );

    assign w_out_head            = t_record'(w_out_q);
    assign o_record_kind         = w_out_head.record_kind;
    assign o_line_number         = w_out_head.line_number;
    assign o_word_index          = w_out_head.word_index;
    assign o_line_hit_count      = w_out_head.line_hit_count;
    assign o_line_length         = w_out_head.line_length;
    assign o_total_hits          = w_out_head.total_hits;
    assign o_total_hit_lines     = w_out_head.total_hit_lines;
    assign o_longest_length      = w_out_head.longest_length;
    assign o_longest_line_number = w_out_head.longest_line_number;
    assign o_last_of_step        = w_out_head.last_of_step;

    // every queued event has something to report
    a_ev_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_ev_empty && !w_ev_head.hit) |-> w_ev_head.line_close)
        else $error("queued event carries neither a word hit nor a line close");

    // the record stage never writes into a full result queue
    a_rec_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rec_push |-> !w_out_full)
        else $error("record written while result queue is full");

    // end of text always closes a line, so an event must be queued
    a_eot_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_end_of_text) |=> !w_ev_empty)
        else $error("end of text word left no event behind");

    // a line record always ends the records of its byte
    a_line_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_record_kind == KIND_LINE) |-> o_last_of_step)
        else $error("line record not marked as last of its byte");

endmodule
